// File: rtl/wgdp_pkg.sv
// Package for the window gradient direction picker: beat types and helper functions.
`default_nettype none

package wgdp_pkg;

   localparam int CellWidth  = 8;
   localparam int RowWidth   = 5 * CellWidth;
   localparam int KeyWidth   = 2 * CellWidth;
   localparam int NumKeys    = 8;
   localparam int KeyIdxWidth = 3;
   localparam int DirWidth   = 3;

   localparam logic [CellWidth-1:0] CellMin = 8'd0;
   localparam logic [CellWidth-1:0] CellMax = 8'd255;
   localparam logic [CellWidth-1:0] HiFloor = 8'd1;

   typedef logic [CellWidth-1:0]   cell_type;
   typedef logic [KeyWidth-1:0]    key_type;
   typedef logic [KeyIdxWidth-1:0] key_idx_type;

   typedef struct packed {
      logic [RowWidth-1:0] window_row_0;
      logic [RowWidth-1:0] window_row_1;
      logic [RowWidth-1:0] window_row_2;
      logic [RowWidth-1:0] window_row_3;
      logic [RowWidth-1:0] window_row_4;
      logic                mode;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [DirWidth-1:0] direction;
   } rsp_type;

   function automatic cell_type cell_max(input cell_type a, input cell_type b);
      return (a > b) ? a : b;
   endfunction

   // Diagonal keys 0..3 go to even codes, orthogonal keys 4..7 to odd codes.
   function automatic logic [DirWidth-1:0] key_to_dir(input key_idx_type idx);
      logic [DirWidth-1:0] dir;
      dir = {idx[1:0], idx[2]};
      return dir;
   endfunction

endpackage : wgdp_pkg

`default_nettype wire

// File: rtl/window_gradient_direction_pick.sv
// Top level of the window gradient direction picker: three-stage pipeline.
`default_nettype none

//  Channel | Ports                              | Direction | Content
//  --------+------------------------------------+-----------+------------------------------
//  request | req_valid, req_stall, req_payload  | in        | 5x5 window rows and mode bit
//  result  | rsp_valid, rsp_stall, rsp_payload  | out       | found flag and direction code
//
//  One beat enters per cycle while req_stall is low.
//  Stage 1 forms the eight 16-bit keys, stage 2 checks acceptance and runs the first
//  round of the max tournament, stage 3 finishes the tournament into the output register.
//  Each stage holds its own valid bit and advances when the stage after it is empty or
//  moving, so bubbles close up under a result stall and nothing is lost or repeated.
//  Synchronous reset clears the valid bits only.

module window_gradient_direction_pick (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire wgdp_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output wgdp_pkg::rsp_type     rsp_payload
);
   import wgdp_pkg::*;

   // Window cells, indexed [row][col].
   cell_type [4:0][4:0] win_cell;

   cell_type [NumKeys-1:0]       nb;
   cell_type [NumKeys-1:0][4:0]  outer;
   key_type  [NumKeys-1:0]       key_in;

   // Stage 1 registers
   logic                   s1_valid_ff;
   key_type [NumKeys-1:0]  s1_key_ff;
   cell_type               s1_centre_ff;
   logic                   s1_mode_ff;

   // Stage 2 registers
   logic                   s2_valid_ff;
   logic                   s2_good_ff;
   key_type [3:0]          s2_key_ff;
   key_idx_type [3:0]      s2_idx_ff;

   // Stage 3 (output) registers
   logic                   rsp_valid_ff;
   rsp_type                rsp_payload_ff;

   logic adv1;
   logic adv2;
   logic adv3;

   key_type     centre_key;
   logic        good_in;
   key_type     [3:0] r1_key_in;
   key_idx_type [3:0] r1_idx_in;
   key_type     [1:0] r2_key;
   key_idx_type [1:0] r2_idx;
   key_idx_type       win_idx;
   rsp_type           rsp_payload_in;

   // Unpack the rows into cells; column c sits at bits 8c+7..8c.
   always_comb begin
      for (int c = 0; c < 5; c++) begin
         win_cell[0][c] = req_payload.window_row_0[c*CellWidth +: CellWidth];
         win_cell[1][c] = req_payload.window_row_1[c*CellWidth +: CellWidth];
         win_cell[2][c] = req_payload.window_row_2[c*CellWidth +: CellWidth];
         win_cell[3][c] = req_payload.window_row_3[c*CellWidth +: CellWidth];
         win_cell[4][c] = req_payload.window_row_4[c*CellWidth +: CellWidth];
      end
   end

   // Neighbours and the outer cells behind them. Orthogonal keys have three outer
   // cells; repeat the last one to fill the five-wide input, which leaves the max alone.
   always_comb begin
      nb[0] = win_cell[1][1];
      outer[0] = {win_cell[0][2], win_cell[0][1], win_cell[0][0], win_cell[1][0],
                  win_cell[2][0]};
      nb[1] = win_cell[1][3];
      outer[1] = {win_cell[2][4], win_cell[1][4], win_cell[0][4], win_cell[0][3],
                  win_cell[0][2]};
      nb[2] = win_cell[3][3];
      outer[2] = {win_cell[4][2], win_cell[4][3], win_cell[4][4], win_cell[3][4],
                  win_cell[2][4]};
      nb[3] = win_cell[3][1];
      outer[3] = {win_cell[2][0], win_cell[3][0], win_cell[4][0], win_cell[4][1],
                  win_cell[4][2]};
      nb[4] = win_cell[1][2];
      outer[4] = {win_cell[0][3], win_cell[0][3], win_cell[0][3], win_cell[0][2],
                  win_cell[0][1]};
      nb[5] = win_cell[2][3];
      outer[5] = {win_cell[3][4], win_cell[3][4], win_cell[3][4], win_cell[2][4],
                  win_cell[1][4]};
      nb[6] = win_cell[3][2];
      outer[6] = {win_cell[4][3], win_cell[4][3], win_cell[4][3], win_cell[4][2],
                  win_cell[4][1]};
      nb[7] = win_cell[2][1];
      outer[7] = {win_cell[3][0], win_cell[3][0], win_cell[3][0], win_cell[2][0],
                  win_cell[1][0]};
   end

   for (genvar g = 0; g < NumKeys; g++) begin : g_key
      wgdp_key_unit u_key (
         .nb    (nb[g]),
         .outer (outer[g]),
         .key   (key_in[g])
      );
   end

   // Handshake: a stage advances when the stage after it is empty or moving.
   assign adv3      = !rsp_valid_ff || !rsp_stall;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;

   // Stage 1: capture keys, centre and mode.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_key_ff    <= key_in;
         s1_centre_ff <= win_cell[2][2];
         s1_mode_ff   <= req_payload.mode;
      end
   end

   // Stage 2: acceptance test over all keys, first tournament round.
   // Later key wins a tie, so the right side of each pair takes equality.
   always_comb begin
      centre_key = {s1_centre_ff, s1_centre_ff};
      good_in    = 1'b0;
      for (int d = 0; d < NumKeys; d++) begin
         if (s1_mode_ff) begin
            if (s1_key_ff[d] > centre_key) good_in = 1'b1;
         end else begin
            if (s1_key_ff[d] != '0 && s1_key_ff[d] != centre_key) good_in = 1'b1;
         end
      end
      for (int p = 0; p < 4; p++) begin
         if (s1_key_ff[2*p] <= s1_key_ff[2*p+1]) begin
            r1_key_in[p] = s1_key_ff[2*p+1];
            r1_idx_in[p] = KeyIdxWidth'(2*p+1);
         end else begin
            r1_key_in[p] = s1_key_ff[2*p];
            r1_idx_in[p] = KeyIdxWidth'(2*p);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_good_ff <= good_in;
         s2_key_ff  <= r1_key_in;
         s2_idx_ff  <= r1_idx_in;
      end
   end

   // Stage 3: finish the tournament, map to a direction code, drop it when not found.
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         if (s2_key_ff[2*p] <= s2_key_ff[2*p+1]) begin
            r2_key[p] = s2_key_ff[2*p+1];
            r2_idx[p] = s2_idx_ff[2*p+1];
         end else begin
            r2_key[p] = s2_key_ff[2*p];
            r2_idx[p] = s2_idx_ff[2*p];
         end
      end
      win_idx = (r2_key[0] <= r2_key[1]) ? r2_idx[1] : r2_idx[0];
      rsp_payload_in.found     = s2_good_ff;
      rsp_payload_in.direction = s2_good_ff ? key_to_dir(win_idx) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv3) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule : window_gradient_direction_pick

`default_nettype wire

// File: rtl/wgdp_key_unit.sv
// Key for neighbour nb: {max(outer cells, 1), nb}, or {nb, nb} if nb is 0 or 255.
`default_nettype none

module wgdp_key_unit (
   input  wire wgdp_pkg::cell_type       nb,
   input  wire wgdp_pkg::cell_type [4:0] outer,
   output wgdp_pkg::key_type             key
);
   import wgdp_pkg::*;

   cell_type m01;
   cell_type m23;
   cell_type m4;
   cell_type m0123;
   cell_type hi;

   always_comb begin
      m01   = cell_max(outer[0], outer[1]);
      m23   = cell_max(outer[2], outer[3]);
      m4    = cell_max(outer[4], HiFloor);
      m0123 = cell_max(m01, m23);
      if (nb != CellMin && nb != CellMax) begin
         hi = cell_max(m0123, m4);
      end else begin
         hi = nb;
      end
      key = {hi, nb};
   end

endmodule : wgdp_key_unit

`default_nettype wire
